>>> sv/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the motor feedback frame decoder.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // default table geometry
  localparam int MOTORS_PER_CHANNEL_DEF = 8;
  localparam int QUANTITY_COUNT_DEF     = 5;
  localparam int CHANNEL_COUNT_DEF      = 2;

  // scale coefficient registers, 24 fraction bits
  localparam int SCALE_COUNT = 5;
  localparam int SCALE_W     = 25;
  localparam int VALUE_W     = 48;
  localparam int CNT_W       = 32;

  typedef logic [SCALE_COUNT-1:0][SCALE_W-1:0] scale_arr_t;

  localparam scale_arr_t SCALE_RESET = {
    25'd16777216,  // temperature
    25'd16777216,  // voltage
    25'd23040,     // position
    25'd99666,     // velocity
    25'd16777      // current
  };

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_FILTERED = 3'd2,
    ST_PROC_ERR = 3'd3,
    ST_BAD_READ = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;  // capture the accepted input beat
    logic exec;   // multiply and table read
    logic load;   // table write, counters, result register
  } cmd_t;

endpackage

>>> sv/mfd_ram.sv
// ----------------------------------------------------------------------------
// mfd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mfd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/mfd_ctrl.sv
// ----------------------------------------------------------------------------
// mfd_ctrl
// Sequencer: accept, execute, writeback; owns the result valid flag.
// ----------------------------------------------------------------------------
module mfd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output mfd_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WB   = 2'd2
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;
  logic   accept;

  // result register free or emptying this cycle
  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_WB) && can_load));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.latch     = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (can_load) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? S_EXEC : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/mfd_dp.sv
// ----------------------------------------------------------------------------
// mfd_dp
// Datapath: frame checks, payload assembly, scaling multiplier, rounding and
// saturation, quantity table with valid bits, outcome counters, result register.
// ----------------------------------------------------------------------------
module mfd_dp #(
  parameter int MOTORS_PER_CHANNEL = mfd_pkg::MOTORS_PER_CHANNEL_DEF,
  parameter int QUANTITY_COUNT     = mfd_pkg::QUANTITY_COUNT_DEF,
  parameter int CHANNEL_COUNT      = mfd_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mfd_pkg::cmd_t                     cmd,
  input  mfd_pkg::scale_arr_t               scales,
  input  logic [1:0]                        in_opcode,
  input  logic [28:0]                       in_frame_id,
  input  logic [3:0]                        in_frame_length,
  input  logic [1:0]                        in_bus_select,
  input  logic [7:0]                        in_command_byte,
  input  logic [31:0]                       in_payload,
  input  logic [2:0]                        in_quantity,
  input  logic [3:0]                        in_read_motor,
  output logic [2:0]                        out_status,
  output logic signed [mfd_pkg::VALUE_W-1:0] out_value
);

  localparam int DEPTH = QUANTITY_COUNT * CHANNEL_COUNT * MOTORS_PER_CHANNEL;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int VW    = mfd_pkg::VALUE_W;
  localparam int CW    = mfd_pkg::CNT_W;

  localparam logic [7:0] MOT8 = 8'(MOTORS_PER_CHANNEL);
  localparam logic [7:0] CH8  = 8'(CHANNEL_COUNT);
  localparam logic [3:0] MOT4 = 4'(MOTORS_PER_CHANNEL);
  localparam logic [3:0] QCNT = 4'(QUANTITY_COUNT);

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_FRAME    = 2'd0,
    OP_READ_QTY = 2'd1,
    OP_READ_CNT = 2'd2
  } opcode_t;

  localparam logic [2:0] CNT_PROCESSED = 3'd0;
  localparam logic [2:0] CNT_BAD_LEN   = 3'd1;
  localparam logic [2:0] CNT_FILTERED  = 3'd2;
  localparam logic [2:0] CNT_ERROR     = 3'd3;

  localparam logic [4:0][7:0] CMD_CODES = {8'h32, 8'h14, 8'h08, 8'h06, 8'h04};

  // latched input beat
  opcode_t     op_r;
  logic [10:0] id_r;
  logic [3:0]  len_r;
  logic        ch_r;
  logic [7:0]  code_r;
  logic [31:0] pay_r;
  logic [2:0]  sel_r;
  logic [3:0]  rmot_r;

  logic signed [57:0] prod_r;
  logic               rd_vld_r;
  logic [DEPTH-1:0]   valid_r;
  logic [CW-1:0]      processed_r, bad_len_r, filtered_r, error_r;
  mfd_pkg::status_t   out_status_r;
  logic signed [VW-1:0] out_value_r;

  logic                len_bad, filt, id_bad, rd_bad, qhit;
  logic [2:0]          qidx;
  mfd_pkg::status_t    frame_st, res_st;
  logic signed [32:0]  raw;
  logic [24:0]         coef;
  logic signed [58:0]  prod_full;
  logic signed [58:0]  rnd;
  logic signed [50:0]  shr;
  logic signed [VW-1:0] sat_val, res_val;
  logic [7:0]          wr_lin, rd_lin;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  logic                wr_en;
  logic [VW-1:0]       ram_rd;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= opcode_t'(in_opcode);
      id_r   <= in_frame_id[10:0];
      len_r  <= in_frame_length;
      ch_r   <= (in_bus_select != 2'd1);
      code_r <= in_command_byte;
      pay_r  <= in_payload;
      sel_r  <= in_quantity;
      rmot_r <= in_read_motor;
    end
  end

  // frame checks, in priority order
  always_comb begin
    qhit = 1'b0;
    qidx = 3'd0;
    for (int i = 4; i >= 0; i--) begin
      if (code_r == CMD_CODES[i]) begin
        qhit = 1'b1;
        qidx = 3'(i);
      end
    end
    len_bad = (len_r == 4'd0) || (len_r > 4'd8);
    filt    = (id_r[7:0] == 8'd0) || (id_r[7:0] > 8'd8);
    id_bad  = (id_r == 11'd0) || (id_r > 11'd8) || !qhit ||
              ({1'b0, qidx} >= QCNT) || ((id_r[3:0] - 4'd1) >= MOT4);
    if (len_bad)     frame_st = mfd_pkg::ST_BAD_LEN;
    else if (filt)   frame_st = mfd_pkg::ST_FILTERED;
    else if (id_bad) frame_st = mfd_pkg::ST_PROC_ERR;
    else             frame_st = mfd_pkg::ST_OK;
    rd_bad = ({1'b0, sel_r} >= QCNT) || (rmot_r == 4'd0) || (rmot_r > MOT4);
  end

  // payload: short frames are unsigned, full frames two's complement
  always_comb begin
    case (len_r)
      4'd1:    raw = '0;
      4'd2:    raw = {25'd0, pay_r[7:0]};
      4'd3:    raw = {17'd0, pay_r[15:0]};
      4'd4:    raw = {9'd0, pay_r[23:0]};
      default: raw = {pay_r[31], pay_r};
    endcase
  end

  assign coef      = scales[qidx];
  assign prod_full = raw * $signed({1'b0, coef});

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      prod_r <= prod_full[57:0];
    end
  end

  // round to 16 fraction bits, saturate to the value range
  always_comb begin
    rnd = {prod_r[57], prod_r} + 59'sd128;
    shr = rnd[58:8];
    if (shr[50:47] == {4{shr[47]}}) sat_val = shr[VW-1:0];
    else if (shr[50])                sat_val = VAL_MIN;
    else                             sat_val = VAL_MAX;
  end

  // table addressing: quantity, then channel, then motor
  assign wr_lin  = ((8'(qidx) * CH8) + 8'(ch_r)) * MOT8 + 8'(id_r[3:0] - 4'd1);
  assign rd_lin  = ((8'(sel_r) * CH8) + 8'(ch_r)) * MOT8 + 8'(rmot_r - 4'd1);
  assign wr_addr = wr_lin[IDX_W-1:0];
  assign rd_addr = rd_bad ? '0 : rd_lin[IDX_W-1:0];
  assign wr_en   = cmd.load && (op_r == OP_FRAME) && (frame_st == mfd_pkg::ST_OK);

  mfd_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (sat_val),
    .rd_en   (cmd.exec),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // entry valid bits give the all-zero reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (cmd.exec) rd_vld_r <= !rd_bad && valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      processed_r <= '0;
      bad_len_r   <= '0;
      filtered_r  <= '0;
      error_r     <= '0;
    end else if (cmd.load && (op_r == OP_FRAME)) begin
      case (frame_st)
        mfd_pkg::ST_OK:       processed_r <= processed_r + 1'b1;
        mfd_pkg::ST_BAD_LEN:  bad_len_r   <= bad_len_r + 1'b1;
        mfd_pkg::ST_FILTERED: filtered_r  <= filtered_r + 1'b1;
        default:              error_r     <= error_r + 1'b1;
      endcase
    end
  end

  // result select
  always_comb begin
    res_st  = mfd_pkg::ST_OK;
    res_val = '0;
    case (op_r)
      OP_FRAME: begin
        res_st = frame_st;
        if (frame_st == mfd_pkg::ST_OK) res_val = sat_val;
      end
      OP_READ_QTY: begin
        if (rd_bad) res_st = mfd_pkg::ST_BAD_READ;
        else if (rd_vld_r) res_val = ram_rd;
      end
      OP_READ_CNT: begin
        case (sel_r)
          CNT_PROCESSED: res_val = VW'(processed_r);
          CNT_BAD_LEN:   res_val = VW'(bad_len_r);
          CNT_FILTERED:  res_val = VW'(filtered_r);
          CNT_ERROR:     res_val = VW'(error_r);
          default:       res_st  = mfd_pkg::ST_BAD_READ;
        endcase
      end
      default: res_st = mfd_pkg::ST_BAD_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= res_st;
      out_value_r  <= res_val;
    end
  end

  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

>>> sv/motor_feedback_frame_decoder.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder
// Decodes motor feedback frames into a scaled per-motor quantity table and
// answers table and counter reads.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. When the result register is
// free, the accept cycle latches the beat, the execute cycle runs the
// payload-times-coefficient multiplier and the table read, and the writeback
// cycle rounds, saturates, writes the table, bumps the outcome counters and
// loads the result register, taking the next beat in that same cycle. The
// multiplier register and the one-port table read fill the execute cycle; a
// stalled result register holds the block in writeback. The table reads as
// zero after reset through per-entry valid bits, so no clearing pass is
// needed. Scale coefficients sit on the APB port at byte address 4*i;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder #(
  parameter int MOTORS_PER_CHANNEL = mfd_pkg::MOTORS_PER_CHANNEL_DEF,
  parameter int QUANTITY_COUNT     = mfd_pkg::QUANTITY_COUNT_DEF,
  parameter int CHANNEL_COUNT      = mfd_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // apb configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic [28:0]                        in_frame_id,
  input  logic [3:0]                         in_frame_length,
  input  logic [1:0]                         in_bus_select,
  input  logic [7:0]                         in_command_byte,
  input  logic [31:0]                        in_payload,
  input  logic [2:0]                         in_quantity,
  input  logic [3:0]                         in_read_motor,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_status,
  output logic signed [mfd_pkg::VALUE_W-1:0] out_value
);

  mfd_pkg::scale_arr_t scale_r;
  mfd_pkg::cmd_t       cmd;
  logic [2:0]          reg_idx;
  logic                reg_wr;

  // register index from the word address
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= mfd_pkg::SCALE_RESET;
    end else if (reg_wr && (reg_idx < 3'(mfd_pkg::SCALE_COUNT))) begin
      scale_r[reg_idx] <= pwdata[mfd_pkg::SCALE_W-1:0];
    end
  end

  // unmapped addresses read as zero
  always_comb begin
    prdata = '0;
    if (reg_idx < 3'(mfd_pkg::SCALE_COUNT)) begin
      prdata = 32'(scale_r[reg_idx]);
    end
  end

  // sequencer
  mfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // decode, scale, store, count
  mfd_dp #(
    .MOTORS_PER_CHANNEL (MOTORS_PER_CHANNEL),
    .QUANTITY_COUNT     (QUANTITY_COUNT),
    .CHANNEL_COUNT      (CHANNEL_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .scales          (scale_r),
    .in_opcode       (in_opcode),
    .in_frame_id     (in_frame_id),
    .in_frame_length (in_frame_length),
    .in_bus_select   (in_bus_select),
    .in_command_byte (in_command_byte),
    .in_payload      (in_payload),
    .in_quantity     (in_quantity),
    .in_read_motor   (in_read_motor),
    .out_status      (out_status),
    .out_value       (out_value)
  );

  // the cycle after an accepted beat is always the execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input beat accepted during execute cycle");

  // a loaded result is presented next cycle
  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

  // failed frames and bad reads carry a zero value
  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != mfd_pkg::ST_OK)) |-> (out_value == '0))
    else $error("nonzero value with error status");

endmodule
